@@ hw/rtl/sorted_edge_priority_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// sorted edge priority queue assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SORTED_EDGE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_EDGE_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every edge out of reset
`define SEPQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sepq assertion failed");

// consequent must hold in the cycle after the antecedent
`define SEPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sepq assertion failed");

`else

`define SEPQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define SEPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/sepq_pkg.sv @@
// ----------------------------------------------------------------------------
// sepq_pkg
// shared types and constants of the sorted edge priority queue
// ----------------------------------------------------------------------------
package sepq_pkg;

  localparam int unsigned QueueDepthDef  = 64;
  localparam int unsigned VertexBitsDef  = 6;
  localparam int unsigned PortVertexBits = 6;
  localparam int unsigned WeightBits     = 32;
  localparam int unsigned CountOutBits   = 7;

  // operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_t;

  // request kinds on the input channel
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_POPPED       = 3'd1,
    ST_ZERO_IGNORED = 3'd2,
    ST_POP_EMPTY    = 3'd3,
    ST_FULL_DROPPED = 3'd4
  } status_t;

  // per-cell control handed down the chain
  typedef struct packed {
    op_t  op;
    logic left_disp;  // left neighbor is pushed one place right
    logic left_occ;   // left neighbor holds an entry
    logic self_occ;   // this cell holds an entry
  } cell_ctl_t;

endpackage

@@ hw/rtl/sepq_cell.sv @@
// ----------------------------------------------------------------------------
// sepq_cell
// one slot of the sorted chain: keeps, takes a neighbor or takes the new edge
// ----------------------------------------------------------------------------
module sepq_cell #(
  parameter int unsigned VERTEX_BITS = sepq_pkg::VertexBitsDef
) (
  input  logic                                   clk,
  input  sepq_pkg::cell_ctl_t                    ctl,
  input  logic [VERTEX_BITS-1:0]                 new_from,
  input  logic [VERTEX_BITS-1:0]                 new_to,
  input  logic signed [sepq_pkg::WeightBits-1:0] new_weight,
  input  logic [VERTEX_BITS-1:0]                 left_from,
  input  logic [VERTEX_BITS-1:0]                 left_to,
  input  logic signed [sepq_pkg::WeightBits-1:0] left_weight,
  input  logic [VERTEX_BITS-1:0]                 right_from,
  input  logic [VERTEX_BITS-1:0]                 right_to,
  input  logic signed [sepq_pkg::WeightBits-1:0] right_weight,
  output logic [VERTEX_BITS-1:0]                 from_q,
  output logic [VERTEX_BITS-1:0]                 to_q,
  output logic signed [sepq_pkg::WeightBits-1:0] weight_q,
  output logic                                   disp
);
  import sepq_pkg::*;

  logic [VERTEX_BITS-1:0]       from_r, from_nxt;
  logic [VERTEX_BITS-1:0]       to_r, to_nxt;
  logic signed [WeightBits-1:0] weight_r, weight_nxt;

  // new edge goes ahead of this entry
  assign disp = ctl.self_occ && (new_weight <= weight_r);

  always_comb begin
    from_nxt   = from_r;
    to_nxt     = to_r;
    weight_nxt = weight_r;
    case (ctl.op)
      OP_INSERT: begin
        if (ctl.left_disp) begin
          from_nxt   = left_from;
          to_nxt     = left_to;
          weight_nxt = left_weight;
        end else if (disp || (ctl.left_occ && !ctl.self_occ)) begin
          from_nxt   = new_from;
          to_nxt     = new_to;
          weight_nxt = new_weight;
        end
      end
      OP_POP: begin
        from_nxt   = right_from;
        to_nxt     = right_to;
        weight_nxt = right_weight;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    from_r   <= from_nxt;
    to_r     <= to_nxt;
    weight_r <= weight_nxt;
  end

  assign from_q   = from_r;
  assign to_q     = to_r;
  assign weight_q = weight_r;

endmodule

@@ hw/rtl/sorted_edge_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_edge_priority_queue_core
// minimum-first priority queue of weighted edges held in a sorted cell chain
// ----------------------------------------------------------------------------
// usage:
//   in_*  channel takes one request item: tuser is the request kind (insert
//         or pop), tdata carries the edge (vertices and signed weight)
//   out_* channel returns exactly one result item per request: tuser is the
//         status, tdata the popped edge, the empty flag and the entry count
//   every cell compares its weight against the new edge in parallel and then
//   keeps, shifts right (insert) or shifts left (pop) at the accepting edge, so
//   an item is applied in the cycle it is accepted; its result shows on the
//   output register in the cycle after
//   throughput is one item per cycle while results are taken, set by the chain
//   update and the output register
//   when the receiver stalls, the result is held in the output register and
//   in_tready drops until it is taken, so no item is lost
//   reset (rst_n low, synchronous) empties the queue; cell contents are
//   left as they are and never read until rewritten
// ----------------------------------------------------------------------------
module sorted_edge_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = sepq_pkg::QueueDepthDef,
  parameter int unsigned VERTEX_BITS = sepq_pkg::VertexBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // edge_from[5:0], edge_to[11:6], edge_weight[43:12], zero pad
  input  logic        in_tuser,   // req_type[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_from[5:0], out_to[11:6], out_weight[43:12],
                                  // is_empty[44], entry_count[51:45], zero pad
  output logic [2:0]  out_tuser   // status[2:0]
);
  import sepq_pkg::*;

  `include "sorted_edge_priority_queue_core_macros.svh"

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PV = PortVertexBits;
  localparam int unsigned WB = WeightBits;

  // input unpacking
  logic                   in_fire;
  req_t                   req;
  logic [VERTEX_BITS-1:0] new_from, new_to;
  logic signed [WB-1:0]   new_weight;

  assign in_fire    = in_tvalid && in_tready;
  assign req        = req_t'(in_tuser);
  assign new_from   = VERTEX_BITS'(in_tdata[PV-1:0]);
  assign new_to     = VERTEX_BITS'(in_tdata[2*PV-1:PV]);
  assign new_weight = $signed(in_tdata[2*PV+WB-1:2*PV]);

  // entry count, the only control state of the chain
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty;

  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // chain wiring
  logic [VERTEX_BITS-1:0] c_from   [QUEUE_DEPTH];
  logic [VERTEX_BITS-1:0] c_to     [QUEUE_DEPTH];
  logic signed [WB-1:0]   c_weight [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_disp;
  logic [QUEUE_DEPTH-1:0] c_occ;

  // request decode
  op_t     op;
  status_t status;

  always_comb begin
    op        = OP_HOLD;
    status    = ST_ZERO_IGNORED;
    count_nxt = count_r;
    unique case (req)
      REQ_INSERT: begin
        if (new_weight == '0) begin
          status = ST_ZERO_IGNORED;
        end else if (full) begin
          status = ST_FULL_DROPPED;
        end else begin
          status    = ST_INSERTED;
          op        = OP_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status = ST_POP_EMPTY;
        end else begin
          status    = ST_POPPED;
          op        = OP_POP;
          count_nxt = count_r - CW'(1);
        end
      end
      default: ;
    endcase
    if (!in_fire) begin
      op        = OP_HOLD;
      count_nxt = count_r;
    end
  end

  // the row of cells
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      cell_ctl_t              ctl;
      logic [VERTEX_BITS-1:0] l_from, l_to, r_from, r_to;
      logic signed [WB-1:0]   l_weight, r_weight;

      assign c_occ[gi] = (CW'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign ctl.left_disp = 1'b0;
        assign ctl.left_occ  = 1'b1;
        assign l_from        = new_from;
        assign l_to          = new_to;
        assign l_weight      = new_weight;
      end else begin : g_body
        assign ctl.left_disp = c_disp[gi-1];
        assign ctl.left_occ  = c_occ[gi-1];
        assign l_from        = c_from[gi-1];
        assign l_to          = c_to[gi-1];
        assign l_weight      = c_weight[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign r_from   = c_from[gi];
        assign r_to     = c_to[gi];
        assign r_weight = c_weight[gi];
      end else begin : g_inner
        assign r_from   = c_from[gi+1];
        assign r_to     = c_to[gi+1];
        assign r_weight = c_weight[gi+1];
      end

      assign ctl.op       = op;
      assign ctl.self_occ = c_occ[gi];

      sepq_cell #(
        .VERTEX_BITS (VERTEX_BITS)
      ) u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .new_from     (new_from),
        .new_to       (new_to),
        .new_weight   (new_weight),
        .left_from    (l_from),
        .left_to      (l_to),
        .left_weight  (l_weight),
        .right_from   (r_from),
        .right_to     (r_to),
        .right_weight (r_weight),
        .from_q       (c_from[gi]),
        .to_q         (c_to[gi]),
        .weight_q     (c_weight[gi]),
        .disp         (c_disp[gi])
      );
    end
  endgenerate

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [PV-1:0]           res_from_r, res_from_nxt;
  logic [PV-1:0]           res_to_r, res_to_nxt;
  logic [WB-1:0]           res_weight_r, res_weight_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic                    res_empty_r, res_empty_nxt;
  logic [CountOutBits-1:0] res_count_r, res_count_nxt;

  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    res_from_nxt   = res_from_r;
    res_to_nxt     = res_to_r;
    res_weight_nxt = res_weight_r;
    res_status_nxt = res_status_r;
    res_empty_nxt  = res_empty_r;
    res_count_nxt  = res_count_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      res_status_nxt = status;
      res_empty_nxt  = (count_nxt == '0);
      res_count_nxt  = CountOutBits'(count_nxt);
      // only a real pop reports the head edge
      if (op == OP_POP) begin
        res_from_nxt   = PV'(c_from[0]);
        res_to_nxt     = PV'(c_to[0]);
        res_weight_nxt = c_weight[0];
      end else begin
        res_from_nxt   = '0;
        res_to_nxt     = '0;
        res_weight_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_from_r   <= res_from_nxt;
    res_to_r     <= res_to_nxt;
    res_weight_r <= res_weight_nxt;
    res_status_r <= res_status_nxt;
    res_empty_r  <= res_empty_nxt;
    res_count_r  <= res_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_status_r;
  assign out_tdata  = {4'b0000, res_count_r, res_empty_r, res_weight_r, res_to_r, res_from_r};

  // checks
  `SEPQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH))
  `SEPQ_ASSERT_NEXT(a_pop_dec, clk, rst_n, in_fire && (op == OP_POP),
                    count_r == $past(count_r) - CW'(1))
  `SEPQ_ASSERT_ALWAYS(a_pop_nonzero, clk, rst_n,
                      !(out_valid_r && (res_status_r == ST_POPPED)) || (res_weight_r != '0))
  `SEPQ_ASSERT_ALWAYS(a_empty_flag, clk, rst_n,
                      !out_valid_r || (res_empty_r == (res_count_r == '0)))

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted edge priority queue core
// ----------------------------------------------------------------------------
// a short directed table is walked first: empty pops, zero weights, the
// weight extremes and ties among equal weights. Then about 1500 random
// requests follow, grouped as fill runs up to a full queue, drain runs down
// to empty, and mixed traffic. Every accepted request goes through a local
// sorted-queue predictor. Each result is checked field by field against the
// oldest outstanding prediction, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sepq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1500;

  // one stored edge as the predictor keeps it
  typedef struct {
    logic [5:0]         vfrom;
    logic [5:0]         vto;
    logic signed [31:0] weight;
  } held_edge_t;

  // one result item, split into its fields
  typedef struct {
    logic [5:0]         vfrom;
    logic [5:0]         vto;
    logic signed [31:0] weight;
    status_t            status;
    logic               is_empty;
    logic [6:0]         count;
  } edge_result_t;

  // one row of the directed table; fixed holds a result typed in by hand
  typedef struct {
    req_t               kind;
    logic [5:0]         vfrom;
    logic [5:0]         vto;
    logic signed [31:0] weight;
    bit                 typed;
    edge_result_t       fixed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;

  held_edge_t   held_edges[$];       // predictor's copy of the sorted queue
  edge_result_t awaited_results[$];  // predicted results not yet seen
  stim_row_t    directed_rows[$];
  edge_result_t blank_result;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           steady = 1'b0;       // no idling on either side while set

  sorted_edge_priority_queue_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // applies one request to the predictor state and returns its result
  function automatic edge_result_t apply_request(input req_t kind,
                                                 input logic [5:0] vfrom,
                                                 input logic [5:0] vto,
                                                 input logic signed [31:0] w);
    edge_result_t r;
    held_edge_t   e;
    int           pos;
    r.vfrom  = '0;
    r.vto    = '0;
    r.weight = '0;
    if (kind == REQ_INSERT) begin
      if (w == 0) begin
        r.status = ST_ZERO_IGNORED;
      end else if (held_edges.size() >= QueueDepthDef) begin
        r.status = ST_FULL_DROPPED;
      end else begin
        // ahead of the first entry not lighter, so the newest of a tie leads
        pos = held_edges.size();
        for (int k = 0; k < held_edges.size(); k++) begin
          if (w <= held_edges[k].weight) begin
            pos = k;
            break;
          end
        end
        e.vfrom  = vfrom;
        e.vto    = vto;
        e.weight = w;
        held_edges.insert(pos, e);
        r.status = ST_INSERTED;
      end
    end else if (held_edges.size() == 0) begin
      r.status = ST_POP_EMPTY;
    end else begin
      e        = held_edges.pop_front();
      r.vfrom  = e.vfrom;
      r.vto    = e.vto;
      r.weight = e.weight;
      r.status = ST_POPPED;
    end
    r.is_empty = (held_edges.size() == 0);
    r.count    = held_edges.size();
    return r;
  endfunction

  function automatic stim_row_t row(input req_t kind, input logic [5:0] vfrom,
                                    input logic [5:0] vto,
                                    input logic signed [31:0] w, input bit typed,
                                    input status_t st, input logic [5:0] rfrom,
                                    input logic [5:0] rto,
                                    input logic signed [31:0] rw,
                                    input logic [6:0] cnt);
    stim_row_t s;
    s.kind            = kind;
    s.vfrom           = vfrom;
    s.vto             = vto;
    s.weight          = w;
    s.typed           = typed;
    s.fixed.vfrom     = rfrom;
    s.fixed.vto       = rto;
    s.fixed.weight    = rw;
    s.fixed.status    = st;
    s.fixed.is_empty  = (cnt == 0);
    s.fixed.count     = cnt;
    return s;
  endfunction

  // mostly full-range weights, with a narrow band for ties and the extremes
  function automatic logic signed [31:0] pick_weight(input bit allow_zero);
    int unsigned        roll;
    logic signed [31:0] w;
    roll = $urandom_range(0, 99);
    if (allow_zero && roll < 8) return '0;
    if (roll < 30) begin
      w = $urandom_range(0, 6);
      w = w - 3;
    end else if (roll < 38) begin
      case ($urandom_range(0, 3))
        0: w = 32'sh80000000;
        1: w = 32'sh7fffffff;
        2: w = -1;
        default: w = 1;
      endcase
    end else begin
      w = $urandom;
    end
    if (w == 0) w = 1;
    return w;
  endfunction

  // offers one item, holds it until taken and records its expected result
  task automatic send_item(input req_t kind, input logic [5:0] vfrom,
                           input logic [5:0] vto, input logic signed [31:0] w,
                           input bit typed, input edge_result_t fixed);
    edge_result_t r;
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, w, vto, vfrom};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_request(kind, vfrom, vto, w);
    awaited_results.push_back(typed ? fixed : r);
  endtask

  task automatic send_random(input req_t kind, input logic signed [31:0] w);
    send_item(kind, $urandom_range(0, 63), $urandom_range(0, 63), w, 1'b0,
              blank_result);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // result side: check what was taken at this edge, then pick the next ready
  always @(posedge clk) begin
    edge_result_t got;
    edge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.vfrom    = out_tdata[5:0];
      got.vto      = out_tdata[11:6];
      got.weight   = out_tdata[43:12];
      got.is_empty = out_tdata[44];
      got.count    = out_tdata[51:45];
      got.status   = status_t'(out_tuser);
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", got.status, want.status);
        check_field("from", got.vfrom, want.vfrom);
        check_field("to", got.vto, want.vto);
        check_field("weight", got.weight, want.weight);
        check_field("is_empty", got.is_empty, want.is_empty);
        check_field("entry_count", got.count, want.count);
      end
    end
    out_tready <= steady || ($urandom_range(0, 99) >= 29);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned run_len;
    stim_row_t   s;
    blank_result.vfrom    = '0;
    blank_result.vto      = '0;
    blank_result.weight   = '0;
    blank_result.status   = ST_INSERTED;
    blank_result.is_empty = 1'b0;
    blank_result.count    = '0;

    // directed table: kind, from, to, weight, typed, status, from, to, weight, count
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 1, ST_POP_EMPTY, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 63, 63, 0, 1, ST_ZERO_IGNORED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 63, 0, 32'sh7fffffff, 1, ST_INSERTED,
                                0, 0, 0, 1));
    directed_rows.push_back(row(REQ_INSERT, 0, 63, 32'sh80000000, 1, ST_INSERTED,
                                0, 0, 0, 2));
    directed_rows.push_back(row(REQ_INSERT, 1, 2, 5, 1, ST_INSERTED, 0, 0, 0, 3));
    // equal weight: the newer edge must come out first
    directed_rows.push_back(row(REQ_INSERT, 3, 4, 5, 0, ST_INSERTED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 5, 6, -1, 0, ST_INSERTED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 7, 8, 1, 0, ST_INSERTED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 9, 10, 0, 1, ST_ZERO_IGNORED, 0, 0, 0, 6));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 1, ST_POPPED, 0, 63, 32'sh80000000, 5));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 11, 12, 7, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 42, 21, 5, 0, ST_INSERTED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 1, ST_POPPED, 63, 0, 32'sh7fffffff, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 1, ST_POP_EMPTY, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 42, 21, 32'sh55555555, 0, ST_INSERTED,
                                0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 21, 42, 32'shaaaaaaaa, 0, ST_INSERTED,
                                0, 0, 0, 0));
    directed_rows.push_back(row(REQ_INSERT, 0, 0, -2, 0, ST_INSERTED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0));
    directed_rows.push_back(row(REQ_POP, 0, 0, 0, 1, ST_POP_EMPTY, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      send_item(s.kind, s.vfrom, s.vto, s.weight, s.typed, s.fixed);
    end
    wait_drained();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // long stretch with both sides running flat out
      steady = (random_sent >= 400 && random_sent < 650);
      if (random_sent >= 700 && random_sent < 760) wait_drained();
      case ($urandom_range(0, 3))
        0: begin
          // fill to full, then knock on the full queue, first with a zero weight
          while (held_edges.size() < QueueDepthDef) begin
            send_random(REQ_INSERT, pick_weight(1'b0));
            random_sent++;
          end
          send_random(REQ_INSERT, 0);
          run_len = $urandom_range(1, 3);
          repeat (run_len) send_random(REQ_INSERT, pick_weight(1'b0));
          random_sent += run_len + 1;
        end
        1: begin
          // drain to empty, then pop past the bottom
          while (held_edges.size() > 0) begin
            send_random(REQ_POP, pick_weight(1'b1));
            random_sent++;
          end
          run_len = $urandom_range(1, 3);
          repeat (run_len) send_random(REQ_POP, pick_weight(1'b1));
          random_sent += run_len;
        end
        default: begin
          // mixed traffic, slightly biased toward inserts
          run_len = $urandom_range(20, 60);
          repeat (run_len) begin
            if ($urandom_range(0, 99) < 55) send_random(REQ_INSERT, pick_weight(1'b1));
            else send_random(REQ_POP, pick_weight(1'b1));
          end
          random_sent += run_len;
        end
      endcase
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
